FILE: rtl/core/afzc_pkg.sv
// Package: shared types and constants for the frame level and zero-crossing block.
package afzc_pkg;

    localparam int MaxFrame = 1024;
    localparam int CntW     = $clog2(MaxFrame + 1);   // sample count width
    localparam int XcW      = CntW - 1;               // crossing count width
    localparam int SumW     = 31 + CntW;              // sum of squares width

    localparam logic [17:0] RateReset    = 18'd44100;
    localparam logic [16:0] LowMinReset  = 17'd20;
    localparam logic [16:0] LowMaxReset  = 17'd3000;
    localparam logic [16:0] MidMaxReset  = 17'd4000;
    localparam logic [16:0] HighMaxReset = 17'd20000;

    typedef enum logic [2:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_LOW_MIN     = 3'd1,
        REG_LOW_MAX     = 3'd2,
        REG_MID_MAX     = 3'd3,
        REG_HIGH_MAX    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        BAND_NONE = 2'd0,
        BAND_LOW  = 2'd1,
        BAND_MID  = 2'd2,
        BAND_HIGH = 2'd3
    } band_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_FREQ,
        ST_BAND,
        ST_OUT
    } back_state_t;

    // frame summary handed from front to back
    typedef struct packed {
        logic [SumW-1:0] sum;
        logic [XcW-1:0]  xings;
        logic [CntW-1:0] n;
    } frame_t;

    typedef struct packed {
        logic [15:0] rms_level;
        logic [16:0] frequency_hz;
        logic [1:0]  band;
        logic [15:0] low_level;
        logic [15:0] mid_level;
        logic [15:0] high_level;
    } result_t;

    typedef struct packed {
        logic [17:0] rate;
        logic [16:0] low_min;
        logic [16:0] low_max;
        logic [16:0] mid_max;
        logic [16:0] high_max;
    } cfg_t;

endpackage

FILE: rtl/core/afzc_if.sv
// Interfaces: sample, result and configuration channels.
interface afzc_sample_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               last;
    modport source (output valid, sample, last, input ready);
    modport sink (input valid, sample, last, output ready);
endinterface

interface afzc_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] rms_level;
    logic [16:0] frequency_hz;
    logic [1:0]  band;
    logic [15:0] low_level;
    logic [15:0] mid_level;
    logic [15:0] high_level;
    modport source (output valid, rms_level, frequency_hz, band, low_level, mid_level,
                    high_level, input ready);
    modport sink (input valid, rms_level, frequency_hz, band, low_level, mid_level,
                  high_level, output ready);
endinterface

interface afzc_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/afzc_front.sv
// Front end: per-sample crossing count and sum of squares, frame closing.
module afzc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [15:0]   sample,
    input  logic                 last,
    output logic                 fr_valid,
    input  logic                 fr_ready,
    output afzc_pkg::frame_t     fr
);
    import afzc_pkg::*;

    logic            prev_neg_reg;
    logic [XcW-1:0]  xc_reg;
    logic [CntW-1:0] cnt_reg;
    logic [SumW-1:0] sum_reg;
    logic            fv_reg;
    frame_t          fr_reg;

    logic            neg;
    logic [15:0]     mag;
    logic [31:0]     sq;
    logic            acc;
    logic            close;
    logic [XcW-1:0]  xc_next;
    logic [CntW-1:0] cnt_next;
    logic [SumW-1:0] sum_next;

    // front may accept while the hand-off slot is free or being drained
    assign in_ready = !fv_reg || fr_ready;
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        neg      = sample[15];
        mag      = neg ? (16'd0 - sample) : sample;
        sq       = mag * mag;
        xc_next  = xc_reg + XcW'((cnt_reg != '0) && (neg != prev_neg_reg));
        cnt_next = cnt_reg + CntW'(1);
        sum_next = sum_reg + SumW'(sq);
        close    = last || (cnt_next == CntW'(MaxFrame));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_neg_reg <= 1'b0;
            xc_reg       <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            fv_reg       <= 1'b0;
        end
        else
        begin
            // hand-off slot: a closing transaction refills it, a drain empties it
            if (acc && close)
                fv_reg <= 1'b1;
            else if (fv_reg && fr_ready)
                fv_reg <= 1'b0;
            if (acc)
            begin
                if (close)
                begin
                    prev_neg_reg <= 1'b0;
                    xc_reg       <= '0;
                    cnt_reg      <= '0;
                    sum_reg      <= '0;
                end
                else
                begin
                    prev_neg_reg <= neg;
                    xc_reg       <= xc_next;
                    cnt_reg      <= cnt_next;
                    sum_reg      <= sum_next;
                end
            end
        end
    end

    // frame summary register
    always_ff @(posedge clk)
    begin
        if (acc && close)
        begin
            fr_reg.sum   <= sum_next;
            fr_reg.xings <= xc_next;
            fr_reg.n     <= cnt_next;
        end
    end

    assign fr_valid = fv_reg;
    assign fr       = fr_reg;
endmodule

FILE: rtl/core/afzc_queue.sv
// Two-entry queue of frame summaries between front and back.
module afzc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  afzc_pkg::frame_t  wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output afzc_pkg::frame_t  rd_data
);
    import afzc_pkg::*;

    frame_t     mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic       wr;
    logic       rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end
endmodule

FILE: rtl/core/afzc_back.sv
// Back end: sum/n divide, integer square root, frequency divide and band choice.
module afzc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  afzc_pkg::cfg_t    cfg,
    input  logic              fr_valid,
    output logic              fr_ready,
    input  afzc_pkg::frame_t  fr,
    output logic              res_valid,
    input  logic              res_ready,
    output afzc_pkg::result_t res
);
    import afzc_pkg::*;

    localparam int NumW = XcW + 18;          // crossings * rate
    localparam int DW   = CntW + 1;          // 2n
    localparam int MW   = 32;                // mean square fits 31 bits
    localparam int CycW = 6;

    back_state_t state_reg, state_next;
    logic [CycW-1:0] cyc_reg, cyc_next;

    logic [SumW-1:0] quo_reg, quo_next;      // shared divide quotient/dividend
    logic [DW:0]     rem_reg, rem_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic [MW-1:0]   rv_reg, rv_next;        // square root working value
    logic [MW-1:0]   root_reg, root_next;
    logic [MW-1:0]   bit_reg, bit_next;
    logic [NumW-1:0] num_reg, num_next;
    logic [15:0]     rms_reg, rms_next;
    logic [16:0]     freq_reg, freq_next;
    logic [2:0]      bi_reg, bi_next;        // band compare step
    band_t           band_reg, band_next;
    logic            ge_lmin_reg, ge_lmin_next;
    logic            le_lmax_reg, le_lmax_next;
    logic            le_mmax_reg, le_mmax_next;
    logic            le_hmax_reg, le_hmax_next;
    logic            ov_reg, ov_next;
    result_t         res_reg, res_next;

    logic [DW:0]     trial;
    logic [MW-1:0]   rb;
    logic [16:0]     bound;
    logic [16+DW:0]  bprod;

    assign fr_ready  = state_reg == ST_IDLE;
    assign res_valid = ov_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cyc_reg     <= cyc_next;
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        dvs_reg     <= dvs_next;
        rv_reg      <= rv_next;
        root_reg    <= root_next;
        bit_reg     <= bit_next;
        num_reg     <= num_next;
        rms_reg     <= rms_next;
        freq_reg    <= freq_next;
        bi_reg      <= bi_next;
        band_reg    <= band_next;
        ge_lmin_reg <= ge_lmin_next;
        le_lmax_reg <= le_lmax_next;
        le_mmax_reg <= le_mmax_next;
        le_hmax_reg <= le_hmax_next;
        res_reg     <= res_next;
    end

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        cyc_next     = cyc_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        rv_next      = rv_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        num_next     = num_reg;
        rms_next     = rms_reg;
        freq_next    = freq_reg;
        bi_next      = bi_reg;
        band_next    = band_reg;
        ge_lmin_next = ge_lmin_reg;
        le_lmax_next = le_lmax_reg;
        le_mmax_next = le_mmax_reg;
        le_hmax_next = le_hmax_reg;
        ov_next      = ov_reg && !res_ready;
        res_next     = res_reg;
        trial        = {rem_reg[DW-1:0], quo_reg[SumW-1]} - {1'b0, dvs_reg};
        rb           = root_reg + bit_reg;
        case (bi_reg)
            3'd0:    bound = cfg.low_min;
            3'd1:    bound = cfg.low_max;
            3'd2:    bound = cfg.mid_max;
            default: bound = cfg.high_max;
        endcase
        bprod        = bound * dvs_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (fr_valid)
                begin
                    quo_next  = fr.sum;
                    rem_next  = '0;
                    dvs_next  = DW'(fr.n);
                    num_next  = fr.xings * cfg.rate;
                    cyc_next  = '0;
                    state_next = ST_DIV;
                end
            end
            // restoring divide, one quotient bit a cycle
            ST_DIV:
            begin
                if (!trial[DW])
                    rem_next = trial;
                else
                    rem_next = {rem_reg[DW-1:0], quo_reg[SumW-1]};
                quo_next = {quo_reg[SumW-2:0], !trial[DW]};
                cyc_next = cyc_reg + CycW'(1);
                if (cyc_reg == CycW'(SumW - 1))
                begin
                    rv_next    = MW'(quo_next);
                    root_next  = '0;
                    bit_next   = MW'(1) << (MW - 2);
                    state_next = ST_SQRT;
                end
            end
            // bitwise integer square root
            ST_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    rms_next   = root_reg[15:0];
                    quo_next   = SumW'(num_reg);
                    rem_next   = '0;
                    dvs_next   = {dvs_reg[DW-2:0], 1'b0};
                    cyc_next   = '0;
                    state_next = ST_FREQ;
                end
                else
                begin
                    if (rv_reg >= rb)
                    begin
                        rv_next   = rv_reg - rb;
                        root_next = (root_reg >> 1) + bit_reg;
                    end
                    else
                        root_next = root_reg >> 1;
                    bit_next = bit_reg >> 2;
                end
            end
            ST_FREQ:
            begin
                if (!trial[DW])
                    rem_next = trial;
                else
                    rem_next = {rem_reg[DW-1:0], quo_reg[SumW-1]};
                quo_next = {quo_reg[SumW-2:0], !trial[DW]};
                cyc_next = cyc_reg + CycW'(1);
                if (cyc_reg == CycW'(SumW - 1))
                begin
                    freq_next  = quo_next[16:0];
                    bi_next    = '0;
                    state_next = ST_BAND;
                end
            end
            // one bound product a cycle
            ST_BAND:
            begin
                case (bi_reg)
                    3'd0:    ge_lmin_next = (17+DW)'(num_reg) >= bprod;
                    3'd1:    le_lmax_next = (17+DW)'(num_reg) <= bprod;
                    3'd2:    le_mmax_next = (17+DW)'(num_reg) <= bprod;
                    default: le_hmax_next = (17+DW)'(num_reg) <= bprod;
                endcase
                bi_next = bi_reg + 3'd1;
                if (bi_reg == 3'd3)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!ov_next)
                begin
                    if (ge_lmin_reg && le_lmax_reg)
                        band_next = BAND_LOW;
                    else if (!le_lmax_reg && le_mmax_reg)
                        band_next = BAND_MID;
                    else if (!le_mmax_reg && le_hmax_reg)
                        band_next = BAND_HIGH;
                    else
                        band_next = BAND_NONE;
                    res_next.rms_level    = rms_reg;
                    res_next.frequency_hz = freq_reg;
                    res_next.band         = band_next;
                    res_next.low_level    = (band_next == BAND_LOW)  ? rms_reg : 16'd0;
                    res_next.mid_level    = (band_next == BAND_MID)  ? rms_reg : 16'd0;
                    res_next.high_level   = (band_next == BAND_HIGH) ? rms_reg : 16'd0;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

FILE: rtl/core/audio_frame_rms_zero_cross_band.sv
// Top level: frame RMS level, zero-crossing frequency and band routing.
// Samples are taken one per cycle; the input stalls only while the frame queue is full.
// Back end: one frame at a time, in order sum/n divide, square root, frequency divide, band compares, hand-off.
// Reset (rst_n low, asynchronous) clears counts, queue and result valid, loads config defaults.
module audio_frame_rms_zero_cross_band (
    input  logic            clk,
    input  logic            rst_n,
    afzc_sample_if.sink     in_ch,
    afzc_result_if.source   out_ch,
    afzc_cfg_if.sink        cfg_ch
);
    import afzc_pkg::*;

    cfg_t    cfg_reg;
    frame_t  f_fr, q_fr;
    logic    f_valid, f_ready, q_valid, q_ready;
    result_t res;

    // configuration registers
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rate     <= RateReset;
            cfg_reg.low_min  <= LowMinReset;
            cfg_reg.low_max  <= LowMaxReset;
            cfg_reg.mid_max  <= MidMaxReset;
            cfg_reg.high_max <= HighMaxReset;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_SAMPLE_RATE: cfg_reg.rate     <= cfg_ch.data[17:0];
                REG_LOW_MIN:     cfg_reg.low_min  <= cfg_ch.data[16:0];
                REG_LOW_MAX:     cfg_reg.low_max  <= cfg_ch.data[16:0];
                REG_MID_MAX:     cfg_reg.mid_max  <= cfg_ch.data[16:0];
                REG_HIGH_MAX:    cfg_reg.high_max <= cfg_ch.data[16:0];
                default: ;
            endcase
        end
    end

    afzc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sample   (in_ch.sample),
        .last     (in_ch.last),
        .fr_valid (f_valid),
        .fr_ready (f_ready),
        .fr       (f_fr)
    );

    afzc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_fr),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_fr)
    );

    afzc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fr_valid  (q_valid),
        .fr_ready  (q_ready),
        .fr        (q_fr),
        .res_valid (out_ch.valid),
        .res_ready (out_ch.ready),
        .res       (res)
    );

    assign out_ch.rms_level    = res.rms_level;
    assign out_ch.frequency_hz = res.frequency_hz;
    assign out_ch.band         = res.band;
    assign out_ch.low_level    = res.low_level;
    assign out_ch.mid_level    = res.mid_level;
    assign out_ch.high_level   = res.high_level;
endmodule
